### design/modexp_pkg.sv
// Shared constants for the modular exponentiation block: register indexes and FSM codes.
package modexp_pkg;

	// Configuration register index port width and register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

	// Sequencer states
	localparam int unsigned ST_W = 3;
	typedef logic [ST_W-1:0] state_t;
	localparam state_t ST_IDLE = 3'd0;
	localparam state_t ST_RED  = 3'd1;
	localparam state_t ST_SQR  = 3'd2;
	localparam state_t ST_MUL  = 3'd3;
	localparam state_t ST_FIN  = 3'd4;

endpackage

### design/modular_exponentiation.sv
// Bit-serial modular exponentiation: result = message ^ exponent mod modulus.
//
// Usage:
//   Input channel (in_valid/in_ready, message) takes one word per item. The
//   output channel (out_valid/out_ready, result) returns one word per item.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge (0 = modulus, 1 = exponent); other indexes are dropped.
//   Write configuration only while the block is idle.
// Operation, from input accept to result valid:
//   the message is first reduced mod modulus, then for each of the WIDTH
//   exponent bits a square is done, plus a multiply by the base when the
//   bit is set, then the result is handed off through the final state.
//   A modulus below two goes straight to the final state and gives 0.
//   A new word can be taken in the same cycle as the result shows.
//   The shared double-and-add modular multiplier does every step and
//   consumes one operand bit per cycle. One item is worked at a time.
// Reset: arst_n clears the sequencer and output valid, loads modulus = 2, exponent = 1.
// Stall: the result waits in an output register; the next item is accepted
//   meanwhile and holds in its final state until that register frees up.
module modular_exponentiation #(
	parameter int unsigned WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [WIDTH-1:0]                   message,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [WIDTH-1:0]                   result,
	input  logic                               cfg_we,
	input  logic [modexp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [WIDTH-1:0]                   cfg_data
);
	import modexp_pkg::*;

	localparam int unsigned CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	// Configuration registers
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] exponent_q;

	// Datapath registers
	state_t           state_q;
	logic [WIDTH-1:0] acc_q;    // running power
	logic [WIDTH-1:0] prod_q;   // partial product / remainder
	logic [WIDTH-1:0] base_q;   // message mod modulus
	logic [WIDTH-1:0] opb_q;    // serial operand, MSB first
	logic [WIDTH-1:0] exp_q;    // exponent bits, MSB first
	logic [CNT_W-1:0] cnt_q;    // operand bit count
	logic [CNT_W-1:0] ecnt_q;   // exponent bit count
	logic             out_valid_q;
	logic [WIDTH-1:0] result_q;

	// One double-and-add step
	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] dbl_r;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] sum_r;
	logic [WIDTH-1:0] opa;
	logic [WIDTH-1:0] step_nxt;
	logic             mul_last;
	logic             exp_last;
	logic             out_free;

	always_comb begin
		// Doubling; during reduction shift in the next message bit instead of zero
		dbl   = {prod_q, (state_q == ST_RED) ? opb_q[WIDTH-1] : 1'b0};
		dbl_r = (dbl >= {1'b0, modulus_q}) ? WIDTH'(dbl - {1'b0, modulus_q}) : dbl[WIDTH-1:0];
		opa   = (state_q == ST_MUL) ? base_q : acc_q;
		sum   = {1'b0, dbl_r} + {1'b0, opa};
		sum_r = (sum >= {1'b0, modulus_q}) ? WIDTH'(sum - {1'b0, modulus_q}) : sum[WIDTH-1:0];
		if (state_q != ST_RED && opb_q[WIDTH-1]) begin
			step_nxt = sum_r;
		end else begin
			step_nxt = dbl_r;
		end
	end

	assign mul_last = (cnt_q == CNT_LAST);
	assign exp_last = (ecnt_q == CNT_LAST);
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WIDTH'(2);
			exponent_q <= WIDTH'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ecnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						ecnt_q  <= '0;
						state_q <= (modulus_q < WIDTH'(2)) ? ST_FIN : ST_RED;
					end
				end
				ST_RED, ST_SQR, ST_MUL: begin
					cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
					if (mul_last) begin
						if (state_q == ST_SQR && exp_q[WIDTH-1]) begin
							state_q <= ST_MUL;
						end else if (state_q == ST_RED) begin
							state_q <= ST_SQR;
						end else begin
							// advance to the next exponent bit
							ecnt_q  <= ecnt_q + 1'b1;
							state_q <= exp_last ? ST_FIN : ST_SQR;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				opb_q  <= message;
				exp_q  <= exponent_q;
				prod_q <= '0;
				acc_q  <= '0;
			end
			ST_RED: begin
				if (mul_last) begin
					base_q <= step_nxt;
					acc_q  <= WIDTH'(1);
					opb_q  <= WIDTH'(1);
					prod_q <= '0;
				end else begin
					prod_q <= step_nxt;
					opb_q  <= opb_q << 1;
				end
			end
			ST_SQR, ST_MUL: begin
				if (mul_last) begin
					acc_q  <= step_nxt;
					opb_q  <= step_nxt;
					prod_q <= '0;
					if (!(state_q == ST_SQR && exp_q[WIDTH-1])) begin
						exp_q <= exp_q << 1;
					end
				end else begin
					prod_q <= step_nxt;
					opb_q  <= opb_q << 1;
				end
			end
			default: ;
		endcase
	end

	// Output register: hold while stalled, load from the final state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			result_q <= acc_q;
		end
	end

endmodule

### design/modexp_chk.sv
// Port-level checker for the modular exponentiation block, with its bind.
module modexp_chk #(
	parameter int unsigned WIDTH = 32
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic [WIDTH-1:0]                   message,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [WIDTH-1:0]                   result,
	input logic                               cfg_we,
	input logic [modexp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [WIDTH-1:0]                   cfg_data
);
	import modexp_pkg::*;

	// Track the modulus from the write port
	logic [WIDTH-1:0] mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WIDTH'(2);
		end else if (cfg_we && cfg_index == REG_MODULUS) begin
			mod_q <= cfg_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result word dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mod_q >= WIDTH'(2) |-> result < mod_q)
		else $error("result not reduced below modulus");

	a_small_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mod_q < WIDTH'(2) |-> result == '0)
		else $error("nonzero result for modulus below two");

endmodule

bind modular_exponentiation modexp_chk #(.WIDTH(WIDTH)) u_modexp_chk (.*);

### test/testbench.sv
// Self-checking testbench for the modular exponentiation block.
module testbench;
	import modexp_pkg::*;

	localparam int unsigned WIDTH = 32;
	// Indexes that map to no register; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int unsigned DRAIN_CYCLES = 2100;   // extra settle time after the last result
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned WORDS_PER_PHASE = 34;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [WIDTH-1:0] message = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [WIDTH-1:0] result;
	logic             cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
	logic [WIDTH-1:0] cfg_data = '0;

	// Shadow copy of the block's registers, reset values
	logic [WIDTH-1:0] cur_modulus = 2;
	logic [WIDTH-1:0] cur_exponent = 1;

	logic [WIDTH-1:0] pending_messages[$];
	logic [WIDTH-1:0] expected_powers[$];

	logic        in_fire = 1'b0;
	bit          idle_on = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned fail_count = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned settings_used = 0;

	modular_exponentiation #(.WIDTH(WIDTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.message  (message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Exact square-and-multiply; 64-bit products never overflow for 32-bit operands.
	function automatic logic [WIDTH-1:0] mod_power(input logic [WIDTH-1:0] base_in);
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] acc;
		if (cur_modulus < 2)
			return '0;
		m = 64'(cur_modulus);
		b = 64'(base_in) % m;
		acc = 64'd1;
		for (int k = WIDTH - 1; k >= 0; k--) begin
			acc = (acc * acc) % m;
			if (cur_exponent[k])
				acc = (acc * b) % m;
		end
		return acc[WIDTH-1:0];
	endfunction

	// Random word, biased toward the modulus boundary and the field extremes
	function automatic logic [WIDTH-1:0] pick_message();
		case ($urandom_range(0, 6))
			0, 1, 2: return $urandom;
			3: return (cur_modulus != 0) ? $urandom % cur_modulus : $urandom;
			4: return cur_modulus - 1;
			5: return cur_modulus;
			default: return $urandom_range(0, 1) ? '1 : WIDTH'($urandom_range(0, 1));
		endcase
	endfunction

	// Sender: bursts of words, separated by random gaps while idling is on; hold each word until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_messages.size() != 0) begin
				in_valid <= 1'b1;
				message <= pending_messages.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					if (!idle_on)
						gap_left <= 0;
					else if ($urandom_range(0, 2) == 0)
						gap_left <= $urandom_range(1, 2500);
					else
						gap_left <= $urandom_range(0, 3);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: rare stalls, some short, some long enough to span a whole item
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 1499) == 0)
				stall_left <= $urandom_range(0, 1) ? $urandom_range(1, 2500) : $urandom_range(1, 6);
		end
	end

	// Monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_powers.push_back(mod_power(message));
				words_sent <= words_sent + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_powers.size() == 0) begin
					$error("result %h arrived with no word outstanding", result);
					fail_count <= fail_count + 1;
				end else begin
					if (result !== expected_powers[0]) begin
						$error("result mismatch: expected %h, actual %h", expected_powers[0],
							result);
						fail_count <= fail_count + 1;
					end
					void'(expected_powers.pop_front());
					words_checked <= words_checked + 1;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_MODULUS)
			cur_modulus = value;
		else if (idx == REG_EXPONENT)
			cur_exponent = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input logic [WIDTH-1:0] modulus_val,
			input logic [WIDTH-1:0] exponent_val);
		write_reg(REG_MODULUS, modulus_val);
		write_reg(REG_EXPONENT, exponent_val);
		settings_used++;
	endtask

	// Wait until every word is sent and every result is back, then let the block settle.
	// Look at the rising edge, where the sender's last update has already landed.
	task automatic settle(input int unsigned extra);
		while (pending_messages.size() != 0 || in_valid || expected_powers.size() != 0)
			@(posedge clk);
		repeat (extra) @(negedge clk);
	endtask

	initial begin
		logic [WIDTH-1:0] mod_pick;
		logic [WIDTH-1:0] exp_pick;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: modulus 2, exponent 1
		settings_used++;
		pending_messages = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};
		settle(8);

		// Largest modulus and an all-ones exponent; message equal to modulus reduces to zero
		idle_on = 1'b1;
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		pending_messages = '{32'd0, 32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
			32'h5555_5555};
		settle(8);

		// Textbook key pair: encrypt with e, decrypt with d
		program_regs(32'd3233, 32'd17);
		pending_messages = '{32'd65, 32'hFFFF_FFFF};
		settle(8);
		write_reg(REG_EXPONENT, 32'd2753);
		cur_exponent = 32'd2753;
		pending_messages = '{32'd2790};
		settle(8);

		// Exponent zero gives one
		program_regs(32'd7, 32'd0);
		pending_messages = '{32'd0, 32'd5, 32'hFFFF_FFFF};
		settle(8);

		// Exponent zero with modulus one gives zero
		program_regs(32'd1, 32'd0);
		pending_messages = '{32'd9};
		settle(8);

		// Modulus zero and modulus one always give zero
		program_regs(32'd0, 32'd5);
		pending_messages = '{32'd123};
		settle(8);
		program_regs(32'd1, 32'hFFFF_FFFF);
		pending_messages = '{32'hFFFF_FFFF};
		settle(8);

		// Writes to spare indexes must leave both registers alone
		program_regs(32'd13, 32'd5);
		write_reg(REG_SPARE_A, 32'd0);
		write_reg(REG_SPARE_B, 32'd1);
		pending_messages = '{32'd2, 32'd15};
		settle(8);

		// Smallest legal modulus with all-ones exponent
		program_regs(32'd2, 32'hFFFF_FFFF);
		pending_messages = '{32'hFFFF_FFFF, 32'd4};
		settle(8);

		// Random phases: fresh registers each time, every third phase without idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 4))
				0: mod_pick = $urandom_range(2, 255);
				1: mod_pick = $urandom;
				2: mod_pick = 32'hFFFF_FFFF;
				3: mod_pick = $urandom_range(2, 65535);
				default: mod_pick = 32'h8000_0000 | $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: exp_pick = $urandom;
				1: exp_pick = 32'd65537;
				2: exp_pick = $urandom_range(1, 31);
				3: exp_pick = 32'hFFFF_FFFF;
				4: exp_pick = $urandom & $urandom;
				default: exp_pick = 32'd0;
			endcase
			idle_on = (p % 3 != 2);
			program_regs(mod_pick, exp_pick);
			for (int i = 0; i < WORDS_PER_PHASE; i++)
				pending_messages.push_back(pick_message());
			settle(8);
		end

		settle(DRAIN_CYCLES);
		$display("Checked %0d of %0d words over %0d register settings",
			words_checked, words_sent, settings_used);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#100000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
design/modexp_pkg.sv
design/modular_exponentiation.sv
design/modexp_chk.sv
test/testbench.sv
